FILE: design/assert_macros.svh
// assertion macros for the rtl files, included by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ASSERT_CLKED(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// clocked assertion on the block clock and reset
`define ASSERT_STD(lbl, prop) `ASSERT_CLKED(lbl, aclk, aresetn, prop)

`endif

FILE: design/blpi_pkg.sv
// shared types, constants and helpers of the buffer level pi controller
`default_nettype none
package blpi_pkg;

    localparam int LVL_W      = 32;
    localparam int EL_W       = 20;
    localparam int LIM_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int S_DATA_W   = 56;
    localparam int MA_W       = 53;
    localparam int MB_W       = 53;
    localparam int MP_W       = MA_W + MB_W;
    localparam int DN_W       = 53;
    localparam int ACC_W      = 58;
    localparam int MAG_W      = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET    = 3'd0,
        REG_AVG_TIME  = 3'd1,
        REG_PROP_GAIN = 3'd2,
        REG_INT_GAIN  = 3'd3,
        REG_SLEW      = 3'd4,
        REG_LIMIT     = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRIME, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT,
        ST_ERR, ST_SUM, ST_DELTA, ST_CORR, ST_INT, ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        OP_DIFF, OP_PROP, OP_TERM, OP_INC, OP_SLEW
    } mul_op_t;

    typedef struct packed {
        logic signed [31:0] target;
        logic [19:0]        avg_time;
        logic [31:0]        prop_gain;
        logic [39:0]        int_gain;
        logic [39:0]        slew;
        logic [LIM_W-1:0]   limit;
    } cfg_t;

    typedef struct packed {
        logic    lat_in;
        logic    prime;
        logic    diff_load;
        logic    mul_start;
        mul_op_t op;
        logic    mul_cap;
        logic    div_start;
        logic    div_cap;
        logic    err_load;
        logic    sum_load;
        logic    delta_load;
        logic    corr_load;
        logic    int_load;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic el_zero;
        logic need_avg;
        logic mul_done;
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic logic signed [ACC_W-1:0] clamp_sym(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] lim
    );
        logic signed [ACC_W-1:0] r;
        r = v;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/blpi_mul.sv
// sequential multiplier, one 16 bit slice of b per cycle
`default_nettype none
module blpi_mul import blpi_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [MA_W-1:0] a,
    input  wire logic [MB_W-1:0] b,
    output logic                 done,
    output logic [MP_W-1:0]      prod
);
    localparam int CH_W  = 16;
    localparam int CH_N  = (MB_W + CH_W - 1) / CH_W;
    localparam int CNT_W = $clog2(CH_N);
    localparam int BP_W  = CH_N * CH_W;

    logic [MA_W-1:0]      a_reg;
    logic [BP_W-1:0]      b_reg;
    logic [MP_W-1:0]      acc_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [CH_W-1:0]      chunk;
    logic [MA_W+CH_W-1:0] part;
    logic [MP_W-1:0]      shifted;

    always_comb begin
        chunk   = b_reg[cnt_reg*CH_W +: CH_W];
        part    = (MA_W+CH_W)'(a_reg) * (MA_W+CH_W)'(chunk);
        shifted = MP_W'(part) << (cnt_reg * CH_W);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CH_N - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= BP_W'(b);
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + shifted;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

FILE: design/blpi_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module blpi_div import blpi_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [DN_W-1:0] num,
    input  wire logic [EL_W-1:0] den,
    output logic                 done,
    output logic [DN_W-1:0]      quo
);
    localparam int CNT_W = $clog2(DN_W);

    logic [DN_W-1:0]  num_reg;
    logic [EL_W-1:0]  den_reg;
    logic [EL_W:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [EL_W:0]    trial;
    logic             ge;

    always_comb begin
        trial = {rem_reg[EL_W-1:0], num_reg[DN_W-1]};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DN_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? trial - {1'b0, den_reg} : trial;
            num_reg <= {num_reg[DN_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule
`default_nettype wire

FILE: design/blpi_dp.sv
// datapath: loop state, shared multiplier, divider and result register
`default_nettype none
`include "assert_macros.svh"
module blpi_dp import blpi_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cmd_t             cmd,
    output sts_t                  sts,
    input  wire cfg_t             cfg,
    input  wire logic [LVL_W-1:0] in_level,
    input  wire logic [EL_W-1:0]  in_elapsed,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output logic [LVL_W-1:0]      m_corr,
    output logic                  m_clamped,
    output logic                  m_updated
);
    localparam int PROP_SH = 16;
    localparam int INC_SH  = 40;
    localparam int SLEW_SH = 16;

    // loop state
    logic signed [31:0] avg_reg;
    logic signed [31:0] integ_reg;
    logic signed [31:0] corr_reg;
    logic               primed_reg;
    logic               m_tvalid_reg;

    // working registers
    logic signed [31:0]       lvl_reg;
    logic [EL_W-1:0]          el_reg;
    logic                     upd_reg;
    logic [MAG_W-1:0]         dm_reg;
    logic                     dneg_reg;
    logic [MAG_W-1:0]         emag_reg;
    logic                     eneg_reg;
    logic [DN_W-1:0]          t_reg;
    logic signed [ACC_W-1:0]  prop_reg;
    logic signed [ACC_W-1:0]  inc_reg;
    logic signed [ACC_W-1:0]  maxd_reg;
    logic signed [ACC_W-1:0]  wanted_reg;
    logic signed [ACC_W-1:0]  delta_reg;
    logic [LVL_W-1:0]         m_corr_reg;
    logic                     m_clamped_reg;
    logic                     m_updated_reg;

    logic [MA_W-1:0]         mul_a;
    logic [MB_W-1:0]         mul_b;
    logic                    mul_done;
    logic [MP_W-1:0]         mul_prod;
    logic                    div_done;
    logic [DN_W-1:0]         div_quo;
    logic signed [ACC_W-1:0] lim_w;
    logic signed [ACC_W-1:0] diff_w;
    logic signed [ACC_W-1:0] err_w;
    logic signed [ACC_W-1:0] step_w;
    logic signed [ACC_W-1:0] prop_mag;
    logic signed [ACC_W-1:0] inc_mag;
    logic signed [ACC_W-1:0] corr_w;
    logic signed [ACC_W-1:0] corr_mag;
    logic signed [ACC_W-1:0] integ_w;
    logic signed [ACC_W-1:0] integ_mag;
    logic signed [ACC_W-1:0] corr_new;
    logic signed [ACC_W-1:0] integ_new;

    always_comb begin
        lim_w     = ACC_W'(cfg.limit);
        diff_w    = ACC_W'(lvl_reg) - ACC_W'(avg_reg);
        err_w     = ACC_W'(avg_reg) - ACC_W'(cfg.target);
        step_w    = ACC_W'(div_quo[MAG_W-1:0]);
        prop_mag  = ACC_W'(mul_prod[PROP_SH +: 49]);
        inc_mag   = ACC_W'(mul_prod[INC_SH +: 53]);
        corr_w    = ACC_W'(corr_reg);
        corr_mag  = corr_w[ACC_W-1] ? -corr_w : corr_w;
        integ_w   = ACC_W'(integ_reg);
        integ_mag = integ_w[ACC_W-1] ? -integ_w : integ_w;
        corr_new  = clamp_sym(corr_w + delta_reg, lim_w);
        integ_new = clamp_sym(corr_w - prop_reg, lim_w);
    end

    // operand select of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_DIFF: begin
                mul_a = MA_W'(dm_reg);
                mul_b = MB_W'(el_reg);
            end
            OP_PROP: begin
                mul_a = MA_W'(cfg.prop_gain);
                mul_b = MB_W'(emag_reg);
            end
            OP_TERM: begin
                mul_a = MA_W'(emag_reg);
                mul_b = MB_W'(el_reg);
            end
            OP_INC: begin
                mul_a = t_reg;
                mul_b = MB_W'(cfg.int_gain);
            end
            OP_SLEW: begin
                mul_a = MA_W'(cfg.slew);
                mul_b = MB_W'(el_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    blpi_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    blpi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (mul_prod[DN_W-1:0]),
        .den     (cfg.avg_time),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        sts.el_zero  = in_elapsed == '0;
        sts.need_avg = primed_reg && (cfg.avg_time != '0) && (el_reg < cfg.avg_time);
        sts.mul_done = mul_done;
        sts.div_done = div_done;
        sts.out_free = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg      <= '0;
            integ_reg    <= '0;
            corr_reg     <= '0;
            primed_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.prime) begin
                avg_reg    <= lvl_reg;
                primed_reg <= 1'b1;
            end else if (cmd.div_cap) begin
                avg_reg <= 32'(ACC_W'(avg_reg) + (dneg_reg ? -step_w : step_w));
            end
            if (cmd.corr_load) begin
                corr_reg <= 32'(corr_new);
            end
            if (cmd.int_load) begin
                integ_reg <= 32'(integ_new);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lat_in) begin
            lvl_reg <= in_level;
            el_reg  <= in_elapsed;
            upd_reg <= in_elapsed != '0;
        end
        if (cmd.diff_load) begin
            dneg_reg <= diff_w[ACC_W-1];
            dm_reg   <= MAG_W'(diff_w[ACC_W-1] ? -diff_w : diff_w);
        end
        if (cmd.err_load) begin
            eneg_reg <= err_w[ACC_W-1];
            emag_reg <= MAG_W'(err_w[ACC_W-1] ? -err_w : err_w);
        end
        if (cmd.mul_cap) begin
            case (cmd.op)
                OP_PROP: prop_reg <= eneg_reg ? -prop_mag : prop_mag;
                OP_TERM: t_reg    <= mul_prod[DN_W-1:0];
                OP_INC:  inc_reg  <= eneg_reg ? -inc_mag : inc_mag;
                OP_SLEW: maxd_reg <= ACC_W'(mul_prod[SLEW_SH +: 44]);
                default: ;
            endcase
        end
        if (cmd.sum_load) begin
            wanted_reg <= integ_w + inc_reg + prop_reg;
        end
        if (cmd.delta_load) begin
            delta_reg <= clamp_sym(wanted_reg - corr_w, maxd_reg);
        end
        if (cmd.out_load) begin
            m_corr_reg    <= corr_reg;
            m_clamped_reg <= corr_mag >= lim_w;
            m_updated_reg <= upd_reg;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_corr    = m_corr_reg;
    assign m_clamped = m_clamped_reg;
    assign m_updated = m_updated_reg;

    `ASSERT_STD(a_avg_step_fits, cmd.div_cap |-> (div_quo[DN_W-1:MAG_W] == '0))
    `ASSERT_STD(a_corr_in_limit, cmd.corr_load |=> (corr_mag <= lim_w))
    `ASSERT_STD(a_integ_in_limit, cmd.int_load |=> (integ_mag <= lim_w))

endmodule
`default_nettype wire

FILE: design/blpi_ctrl.sv
// controller: sequences one update through the datapath
`default_nettype none
module blpi_ctrl import blpi_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);
    state_t  state_reg;
    state_t  state_next;
    mul_op_t op_reg;
    mul_op_t op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_DIFF;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.op     = op_reg;
        state_next = state_reg;
        op_next    = op_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.lat_in = 1'b1;
                    state_next = sts.el_zero ? ST_RESULT : ST_PRIME;
                end
            end
            ST_PRIME: begin
                if (sts.need_avg) begin
                    cmd.diff_load = 1'b1;
                    op_next       = OP_DIFF;
                    state_next    = ST_MUL_GO;
                end else begin
                    cmd.prime  = 1'b1;
                    state_next = ST_ERR;
                end
            end
            ST_MUL_GO: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (sts.mul_done) begin
                    cmd.mul_cap = 1'b1;
                    case (op_reg)
                        OP_DIFF: state_next = ST_DIV_GO;
                        OP_PROP: begin
                            op_next    = OP_TERM;
                            state_next = ST_MUL_GO;
                        end
                        OP_TERM: begin
                            op_next    = OP_INC;
                            state_next = ST_MUL_GO;
                        end
                        OP_INC: begin
                            op_next    = OP_SLEW;
                            state_next = ST_MUL_GO;
                        end
                        OP_SLEW: state_next = ST_SUM;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    cmd.div_cap = 1'b1;
                    state_next  = ST_ERR;
                end
            end
            ST_ERR: begin
                cmd.err_load = 1'b1;
                op_next      = OP_PROP;
                state_next   = ST_MUL_GO;
            end
            ST_SUM: begin
                cmd.sum_load = 1'b1;
                state_next   = ST_DELTA;
            end
            ST_DELTA: begin
                cmd.delta_load = 1'b1;
                state_next     = ST_CORR;
            end
            ST_CORR: begin
                cmd.corr_load = 1'b1;
                state_next    = ST_INT;
            end
            ST_INT: begin
                cmd.int_load = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: design/buffer_level_pi_ratio_controller.sv
// top level of the buffer level pi ratio controller
//
//  channel | direction | signals                          | content
//  s_      | in        | s_tvalid s_tready s_tdata        | level sample request
//  m_      | out       | m_tvalid m_tready m_tdata m_tuser| correction result
//  cfg_    | in        | cfg_valid cfg_ready cfg_index    | register write
//          |           | cfg_data                         |
//
//  an applied request runs five multiplier passes with averaging and four without,
//  each a start, four 16 bit slices and a capture, and with averaging also the 53
//  step divider; a request with zero elapsed time skips the arithmetic and only
//  loads the output register
//  one request is worked on at a time; the next is taken once the result sits
//  in the output register, which then waits for m_tready
//  aresetn is synchronous and active low and clears loop state and the configuration registers
`default_nettype none
module buffer_level_pi_ratio_controller import blpi_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // slave side
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,    // level[31:0], elapsed_us[51:32], zero pad
    // master side
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [LVL_W-1:0]           m_tdata,    // correction[31:0]
    output logic [1:0]                 m_tuser,    // clamped[0], updated[1]
    // register writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic m_clamped;
    logic m_updated;

    // writes are always taken, unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TARGET:    cfg_reg.target    <= cfg_data[31:0];
                REG_AVG_TIME:  cfg_reg.avg_time  <= cfg_data[19:0];
                REG_PROP_GAIN: cfg_reg.prop_gain <= cfg_data[31:0];
                REG_INT_GAIN:  cfg_reg.int_gain  <= cfg_data[39:0];
                REG_SLEW:      cfg_reg.slew      <= cfg_data[39:0];
                REG_LIMIT:     cfg_reg.limit     <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    blpi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, loop state and the output register
    blpi_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .cfg        (cfg_reg),
        .in_level   (s_tdata[LVL_W-1:0]),
        .in_elapsed (s_tdata[LVL_W +: EL_W]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_corr     (m_tdata),
        .m_clamped  (m_clamped),
        .m_updated  (m_updated)
    );

    assign m_tuser = {m_updated, m_clamped};

endmodule
`default_nettype wire

FILE: bench/buffer_level_pi_ratio_controller_tb.sv
// self-checking bench for the buffer level pi ratio controller
module buffer_level_pi_ratio_controller_tb;
    import blpi_pkg::*;

    localparam int  STALL_LIMIT = 4000;   // cycles without any transfer before giving up
    localparam int  SETTLE      = 120;    // idle wait before register writes and before the summary
    localparam longint SAT_CAP  = 64'sd1 << 60;

    // correction result as the block should report it
    typedef struct {
        logic signed [31:0] correction;
        logic               clamped;
        logic               updated;
    } correction_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;   // level[31:0], elapsed_us[51:32], zero pad
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [LVL_W-1:0]      m_tdata;        // correction[31:0]
    logic [1:0]            m_tuser;        // clamped[0], updated[1]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    buffer_level_pi_ratio_controller u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // shadow of the register file
    longint sh_target, sh_avg_time, sh_prop, sh_int, sh_slew, sh_limit;
    // shadow of the loop state
    longint lp_avg, lp_integral, lp_corr;
    bit     lp_primed;

    correction_t pending_q[$];
    int idle_pct  = 0;
    int stall_pct = 0;
    int n_sent = 0, n_applied = 0, n_checked = 0, n_bad = 0, n_configs = 0;
    int quiet_cycles = 0;

    // floor(a*b / 2^sh), saturated
    function automatic longint scaled_product(input logic [63:0] a, input logic [63:0] b,
                                              input int sh);
        logic [127:0] p;
        p = ({64'b0, a} * {64'b0, b}) >> sh;
        if (p > 128'(SAT_CAP)) begin
            return SAT_CAP;
        end
        return longint'(p[63:0]);
    endfunction

    function automatic longint clamp_mag(input longint v, input longint lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // advance the loop shadow by one sample and form the result it gives
    function automatic correction_t next_correction(input logic signed [31:0] lvl,
                                                    input logic [19:0] el);
        correction_t r;
        longint diff, dm, stp, err, emag, prop, inc, delta, maxd;
        logic [63:0] elw;
        elw = {44'b0, el};
        r.updated = (el != 0);
        if (el != 0) begin
            if (!lp_primed || sh_avg_time == 0 || longint'(elw) >= sh_avg_time) begin
                lp_avg = lvl;
                lp_primed = 1'b1;
            end else begin
                diff = longint'(lvl) - lp_avg;
                dm = diff < 0 ? -diff : diff;
                stp = (dm * longint'(elw)) / sh_avg_time;
                lp_avg = diff < 0 ? lp_avg - stp : lp_avg + stp;
            end
            err = lp_avg - sh_target;
            emag = err < 0 ? -err : err;
            prop = scaled_product(sh_prop, emag, 16);
            inc = scaled_product(sh_int, emag * longint'(elw), 40);
            if (err < 0) begin
                prop = -prop;
                inc = -inc;
            end
            delta = lp_integral + inc + prop - lp_corr;
            maxd = (sh_slew * longint'(elw)) >>> 16;
            delta = clamp_mag(delta, maxd);
            lp_corr = clamp_mag(lp_corr + delta, sh_limit);
            lp_integral = clamp_mag(lp_corr - prop, sh_limit);
        end
        r.correction = lp_corr[31:0];
        r.clamped = ((lp_corr < 0 ? -lp_corr : lp_corr) >= sh_limit);
        return r;
    endfunction

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        correction_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("unexpected result: correction %h user %b", m_tdata, m_tuser);
                end
            end else begin
                want = pending_q.pop_front();
                n_checked++;
                if (m_tdata !== want.correction || m_tuser[0] !== want.clamped
                        || m_tuser[1] !== want.updated) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("result %0d: expected %h/%b/%b got %h/%b/%b",
                                 n_checked, want.correction, want.clamped, want.updated,
                                 m_tdata, m_tuser[0], m_tuser[1]);
                    end
                end
            end
        end
    end

    // watchdog on lack of progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // send one level sample and record what it should produce
    task automatic push_sample(input logic signed [31:0] lvl, input logic [19:0] el);
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, el, lvl};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        pending_q.push_back(next_correction(lvl, el));
        n_sent++;
        if (el != 0) n_applied++;
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [39:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // block idle, then rewrite every register
    task automatic apply_settings(input logic [31:0] tgt, input logic [19:0] avg,
                                  input logic [31:0] pg, input logic [39:0] ig,
                                  input logic [39:0] sl, input logic [30:0] lim);
        drain_results();
        repeat (SETTLE) @(posedge aclk);
        write_reg(REG_TARGET, {8'b0, tgt});
        write_reg(REG_AVG_TIME, {20'b0, avg});
        write_reg(REG_PROP_GAIN, {8'b0, pg});
        write_reg(REG_INT_GAIN, ig);
        write_reg(REG_SLEW, sl);
        write_reg(REG_LIMIT, {9'b0, lim});
        cfg_valid <= 1'b0;
        sh_target = longint'(signed'(tgt));
        sh_avg_time = avg;
        sh_prop = pg;
        sh_int = ig;
        sh_slew = sl;
        sh_limit = lim;
        n_configs++;
    endtask

    // gains near a realistic loop, with some full range values mixed in
    task automatic random_settings();
        logic [31:0] tgt;
        tgt = $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(0, 40 << 16));
        apply_settings(tgt,
                       $urandom_range(3) == 0 ? 20'($urandom()) : 20'($urandom_range(0, 20000)),
                       $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(0, 1 << 22)),
                       $urandom_range(3) == 0 ? {8'($urandom()), 32'($urandom())}
                                              : 40'($urandom_range(0, 1 << 30)),
                       $urandom_range(3) == 0 ? {8'($urandom()), 32'($urandom())}
                                              : 40'($urandom_range(0, 1 << 28)),
                       $urandom_range(3) == 0 ? 31'($urandom())
                                              : 31'($urandom_range(0, 2000 << 16)));
    endtask

    task automatic random_sample();
        logic signed [31:0] lvl;
        logic [19:0] el;
        int pick;
        pick = $urandom_range(99);
        lvl = pick < 70 ? 32'(sh_target + $signed($urandom_range(0, 20 << 16)) - (10 << 16))
                        : $urandom();
        pick = $urandom_range(99);
        if (pick < 8) begin
            el = '0;
        end else if (pick < 20) begin
            el = 20'($urandom());
        end else begin
            el = 20'($urandom_range(1, 3000));
        end
        push_sample(lvl, el);
    endtask

    // after reset the limit is zero, so correction must stay pinned at zero
    task automatic test_reset_state();
        push_sample(32'sh0001_0000, 20'd1000);
        push_sample(32'sh7fff_ffff, 20'd0);
        push_sample(-32'sh8000_0000, 20'hfffff);
    endtask

    task automatic test_directed();
        // typical loop, averaging on
        apply_settings(32'd10 << 16, 20'd4000, 32'd3 << 16, 40'd1 << 28, 40'd1 << 26,
                       31'd500 << 16);
        push_sample(32'd12 << 16, 20'd1000);          // primes the average
        push_sample(32'd15 << 16, 20'd1000);          // averaged step
        push_sample(32'd15 << 16, 20'd0);             // ignored
        push_sample(-32'd3 << 16, 20'd3999);
        push_sample(32'd1 << 16, 20'd4000);           // elapsed reaches the average time
        push_sample(32'd9 << 16, 20'd1);
        // averaging off, zero gains
        apply_settings(32'd0, 20'd0, 32'd0, 40'd0, 40'd0, 31'd100);
        push_sample(32'sh1234_5678, 20'd500);
        push_sample(-32'sh1234_5678, 20'd500);
        // every register at its maximum
        apply_settings(32'h7fff_ffff, 20'hfffff, 32'hffff_ffff, 40'hff_ffff_ffff,
                       40'hff_ffff_ffff, 31'h7fff_ffff);
        push_sample(-32'sh8000_0000, 20'hfffff);
        push_sample(32'sh7fff_ffff, 20'd1);
        push_sample(-32'sh8000_0000, 20'd2);
        push_sample(32'sh0, 20'hffffe);
        push_sample(32'sh0, 20'd0);
        // most negative target, tight slew so the slew bound dominates
        apply_settings(32'h8000_0000, 20'd10, 32'd1 << 20, 40'd1 << 32, 40'd1, 31'd7 << 16);
        push_sample(32'sh7fff_ffff, 20'd5);
        push_sample(32'sh7fff_ffff, 20'd3);
        push_sample(32'sh7fff_ffff, 20'd20);
        // zero limit with strong gains
        apply_settings(32'd0, 20'd100, 32'hffff_ffff, 40'hff_ffff_ffff, 40'hff_ffff_ffff, 31'd0);
        push_sample(32'sh4000_0000, 20'd50);
        push_sample(-32'sh4000_0000, 20'd50);
    endtask

    // random phases under several backpressure patterns
    task automatic test_random(input int idle, input int stall, input int count);
        idle_pct = 0;
        stall_pct = 0;
        random_settings();
        idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                // hold off until everything in flight has come back
                drain_results();
            end
            random_sample();
        end
    endtask

    initial begin
        int waited;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        sh_target = 0; sh_avg_time = 0; sh_prop = 0; sh_int = 0; sh_slew = 0; sh_limit = 0;
        lp_avg = 0; lp_integral = 0; lp_corr = 0; lp_primed = 1'b0;
        @(posedge aclk);
        test_reset_state();
        test_directed();
        for (int p = 0; p < 2; p++) begin
            test_random(0, 0, 55);
            test_random(71, 0, 55);
            test_random(0, 71, 55);
            test_random(19, 19, 55);
        end
        drain_results();
        waited = 0;
        while (waited < SETTLE) begin
            @(posedge aclk);
            waited++;
        end
        $display("sent %0d samples (%0d applied) over %0d register settings", n_sent,
                 n_applied, n_configs);
        $display("checked %0d corrections, %0d mismatches", n_checked, n_bad);
        if (n_bad == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
